// ===== design/process_energy_accounting_table_unit_defines.svh =====
// Assertion macros shared by the accounting table RTL.
`ifndef PROCESS_ENERGY_ACCOUNTING_TABLE_UNIT_DEFINES_SVH
`define PROCESS_ENERGY_ACCOUNTING_TABLE_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PEA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pea_pkg.sv =====
// Types, constants and helper functions of the accounting table.
`default_nettype none

package pea_pkg;

	localparam int DEFAULT_SLOTS = 64;
	localparam int IDX_W         = 6;
	localparam int CMD_W         = 3;
	localparam int AMOUNT_W      = 16;
	localparam int DATA_W        = 32;
	localparam int PADDR_W       = 3;
	localparam int REG_IDX_LSB   = 2;

	localparam logic REG_ENERGY_MODE = 1'b0;

	localparam int SCORE_WINDOW   = 40;
	localparam int STREAK_WINDOW  = 4;
	localparam int SLEEP_DECAY    = 2;
	localparam int RUN_WEIGHT     = 2;
	localparam int USAGE_WEIGHT   = 6;
	localparam int STREAK_WEIGHT  = 5;
	localparam int SLEEP_REBATE   = 5;
	localparam int WAKE_COST_NORM = 3;
	localparam int WAKE_COST_ECO  = 8;
	localparam int SW_COST_NORM   = 2;
	localparam int SW_COST_ECO    = 6;

	localparam int WIN_W    = 6;
	localparam int STREAK_W = 3;
	localparam int COST_W   = 4;
	localparam int SMALL_W  = 9;
	localparam int CREDIT_W = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 3'd0,
		CMD_RUN    = 3'd1,
		CMD_SLEEP  = 3'd2,
		CMD_WAKEUP = 3'd3,
		CMD_SWITCH = 3'd4,
		CMD_DECAY  = 3'd5,
		CMD_SCORE  = 3'd6
	} cmd_e_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] run_tick_count;
		logic [DATA_W-1:0] sleep_tick_count;
		logic [DATA_W-1:0] wakeup_count;
		logic [DATA_W-1:0] switch_count;
		logic [DATA_W-1:0] recent_usage;
		logic [DATA_W-1:0] run_streak;
		logic [DATA_W-1:0] last_score;
	} entry_t;

	typedef struct packed {
		logic [DATA_W-1:0]   wake_term;
		logic [DATA_W-1:0]   switch_term;
		logic [SMALL_W-1:0]  small_sum;
		logic [CREDIT_W-1:0] credit;
	} score_terms_t;

	function automatic logic [WIN_W-1:0] cap_window(input logic [DATA_W-1:0] v);
		cap_window = (v > DATA_W'(SCORE_WINDOW)) ? WIN_W'(SCORE_WINDOW) : v[WIN_W-1:0];
	endfunction

	function automatic logic [STREAK_W-1:0] clamp_streak(input logic [DATA_W-1:0] v);
		clamp_streak = (v > DATA_W'(STREAK_WINDOW)) ? STREAK_W'(STREAK_WINDOW)
			: v[STREAK_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/pea_table_mem.sv =====
// Synchronous table memory: one write port, one registered read port.
`default_nettype none

module pea_table_mem #(
	parameter int DEPTH  = pea_pkg::DEFAULT_SLOTS,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire pea_pkg::entry_t   wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output pea_pkg::entry_t        rdata
);

	pea_pkg::entry_t table_q [DEPTH];
	pea_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			table_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= table_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/pea_update.sv =====
// Next-entry logic for the counter commands.
`default_nettype none

module pea_update (
	input  wire pea_pkg::cmd_e_t               cmd,
	input  wire logic [pea_pkg::AMOUNT_W-1:0]  amount,
	input  wire pea_pkg::entry_t               cur,
	output pea_pkg::entry_t                    nxt
);

	logic [pea_pkg::DATA_W-1:0] sleep_drop;
	logic [pea_pkg::DATA_W-1:0] amount_ext;

	assign amount_ext = pea_pkg::DATA_W'(amount);
	assign sleep_drop = pea_pkg::DATA_W'(pea_pkg::SLEEP_DECAY);

	always_comb begin
		nxt = cur;
		case (cmd)
			pea_pkg::CMD_CLEAR: begin
				nxt = '0;
			end
			pea_pkg::CMD_RUN: begin
				nxt.run_tick_count = cur.run_tick_count + 1'b1;
				nxt.recent_usage   = cur.recent_usage + 1'b1;
				nxt.run_streak     = cur.run_streak + 1'b1;
			end
			pea_pkg::CMD_SLEEP: begin
				nxt.sleep_tick_count = cur.sleep_tick_count + 1'b1;
				nxt.run_streak       = '0;
				nxt.recent_usage     = (sleep_drop >= cur.recent_usage) ? '0
					: cur.recent_usage - sleep_drop;
			end
			pea_pkg::CMD_WAKEUP: begin
				nxt.wakeup_count = cur.wakeup_count + 1'b1;
				nxt.run_streak   = '0;
				nxt.recent_usage = cur.recent_usage >> 1;
			end
			pea_pkg::CMD_SWITCH: begin
				nxt.switch_count = cur.switch_count + 1'b1;
			end
			pea_pkg::CMD_DECAY: begin
				nxt.recent_usage = (amount_ext >= cur.recent_usage) ? '0
					: cur.recent_usage - amount_ext;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/pea_score.sv =====
// Weighted score terms and sleep credit of one entry.
`default_nettype none

module pea_score (
	input  wire logic             energy_mode,
	input  wire pea_pkg::entry_t  cur,
	output pea_pkg::score_terms_t terms
);

	logic [pea_pkg::WIN_W-1:0]    run_c;
	logic [pea_pkg::WIN_W-1:0]    usage_c;
	logic [pea_pkg::WIN_W-1:0]    sleep_c;
	logic [pea_pkg::STREAK_W-1:0] streak_c;
	logic [pea_pkg::COST_W-1:0]   wake_cost;
	logic [pea_pkg::COST_W-1:0]   sw_cost;

	always_comb begin
		run_c    = pea_pkg::cap_window(cur.run_tick_count);
		usage_c  = pea_pkg::cap_window(cur.recent_usage);
		sleep_c  = pea_pkg::cap_window(cur.sleep_tick_count);
		streak_c = pea_pkg::clamp_streak(cur.run_streak);

		wake_cost = energy_mode ? pea_pkg::COST_W'(pea_pkg::WAKE_COST_ECO)
			: pea_pkg::COST_W'(pea_pkg::WAKE_COST_NORM);
		sw_cost   = energy_mode ? pea_pkg::COST_W'(pea_pkg::SW_COST_ECO)
			: pea_pkg::COST_W'(pea_pkg::SW_COST_NORM);

		terms.wake_term   = cur.wakeup_count * pea_pkg::DATA_W'(wake_cost);
		terms.switch_term = cur.switch_count * pea_pkg::DATA_W'(sw_cost);
		terms.small_sum   =
			pea_pkg::SMALL_W'(run_c) * pea_pkg::SMALL_W'(pea_pkg::RUN_WEIGHT)
			+ pea_pkg::SMALL_W'(usage_c) * pea_pkg::SMALL_W'(pea_pkg::USAGE_WEIGHT)
			+ pea_pkg::SMALL_W'(streak_c) * pea_pkg::SMALL_W'(pea_pkg::STREAK_WEIGHT);
		// Credit only counts in energy mode; zero leaves the sum untouched.
		terms.credit = energy_mode
			? pea_pkg::CREDIT_W'(sleep_c) * pea_pkg::CREDIT_W'(pea_pkg::SLEEP_REBATE)
			: '0;
	end

endmodule

`default_nettype wire

// ===== design/process_energy_accounting_table_unit.sv =====
// Top level of the per-process energy accounting table.
//
//   channel   ports                                           handshake
//   -------   ---------------------------------------------   --------------------------
//   command   start, busy, command, process_index,            beat on start && !busy
//             decay_amount
//   result    strobe, scored_process, proc_score              one-cycle strobe, no stall
//   config    psel, penable, pwrite, paddr, pwdata, prdata,   write on psel&&penable&&
//             pready                                          pwrite; pready always high
//
// Sequencing: after its beat a counter command holds busy through ST_READ (read
// data lands, write back); compute score holds it through ST_READ, ST_SUM and
// ST_FINAL (terms, sum, credit and write back), and strobe rises in the cycle
// after ST_FINAL. The table read-modify-write sets these steps; busy interlocks the next beat.
// Reset: a clearing pass zeroes all PROCESS_SLOTS entries, one per cycle, busy high.
// Stalls: none from the receiver; an unused code is taken and dropped at once.
`default_nettype none

`include "process_energy_accounting_table_unit_defines.svh"

module process_energy_accounting_table_unit #(
	parameter int PROCESS_SLOTS = pea_pkg::DEFAULT_SLOTS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pea_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [pea_pkg::DATA_W-1:0]    pwdata,
	output logic      [pea_pkg::DATA_W-1:0]    prdata,
	output logic                               pready,
	// command channel
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [pea_pkg::CMD_W-1:0]     command,
	input  wire logic [pea_pkg::IDX_W-1:0]     process_index,
	input  wire logic [pea_pkg::AMOUNT_W-1:0]  decay_amount,
	// result channel
	output logic                               strobe,
	output logic      [pea_pkg::IDX_W-1:0]     scored_process,
	output logic      [pea_pkg::DATA_W-1:0]    proc_score
);

	localparam int SLOT_W = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PROCESS_SLOTS - 1);

	// ---------------------------------------------------------------- config
	logic cfg_write;
	logic energy_mode_q;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_mode_q <= 1'b0;
		end else if (cfg_write && (paddr[pea_pkg::REG_IDX_LSB] == pea_pkg::REG_ENERGY_MODE)) begin
			energy_mode_q <= pwdata[0];
		end
	end

	// Only register zero exists; addresses with paddr[2] set read as zero.
	assign prdata = (paddr[pea_pkg::REG_IDX_LSB] == pea_pkg::REG_ENERGY_MODE)
		? pea_pkg::DATA_W'(energy_mode_q) : '0;

	// ---------------------------------------------------------------- accept
	pea_pkg::state_t state_q, state_d;
	logic            accept;
	logic            item_ok;
	logic            idx_in_range;
	logic [pea_pkg::IDX_W+SLOT_W-1:0] idx_wide;
	logic [pea_pkg::IDX_W+SLOT_W-1:0] idx_wide_s1;
	logic [SLOT_W-1:0] slot_in;
	logic [SLOT_W-1:0] slot_s1;

	assign busy    = (state_q != pea_pkg::ST_IDLE);
	assign accept  = start && !busy;

	assign idx_in_range = (32'(process_index) < 32'(PROCESS_SLOTS));
	assign item_ok      = idx_in_range && (command <= pea_pkg::CMD_SCORE);

	assign idx_wide = {{SLOT_W{1'b0}}, process_index};
	assign slot_in  = idx_wide[SLOT_W-1:0];

	// Hold the beat for the whole read-modify-write.
	pea_pkg::cmd_e_t              cmd_s1;
	logic [pea_pkg::IDX_W-1:0]    idx_s1;
	logic [pea_pkg::AMOUNT_W-1:0] amount_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= pea_pkg::cmd_e_t'(command);
			idx_s1    <= process_index;
			amount_s1 <= decay_amount;
		end
	end

	assign idx_wide_s1 = {{SLOT_W{1'b0}}, idx_s1};
	assign slot_s1     = idx_wide_s1[SLOT_W-1:0];

	// ---------------------------------------------------------------- table
	logic            mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	pea_pkg::entry_t mem_wdata;
	pea_pkg::entry_t rd_entry;
	pea_pkg::entry_t upd_entry;
	pea_pkg::entry_t final_entry;
	logic [SLOT_W-1:0] sweep_q;

	pea_table_mem #(
		.DEPTH  (PROCESS_SLOTS),
		.ADDR_W (SLOT_W)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (slot_in),
		.rdata (rd_entry)
	);

	pea_update u_update (
		.cmd    (cmd_s1),
		.amount (amount_s1),
		.cur    (rd_entry),
		.nxt    (upd_entry)
	);

	// ---------------------------------------------------------------- score path
	pea_pkg::score_terms_t terms;
	pea_pkg::score_terms_t terms_s2;
	pea_pkg::entry_t       entry_s2;
	pea_pkg::entry_t       entry_s3;
	logic [pea_pkg::DATA_W-1:0]   sum_s3;
	logic [pea_pkg::CREDIT_W-1:0] credit_s3;
	logic [pea_pkg::DATA_W-1:0]   score;
	logic [pea_pkg::DATA_W-1:0]   credit_ext;

	pea_score u_score (
		.energy_mode (energy_mode_q),
		.cur         (rd_entry),
		.terms       (terms)
	);

	always_ff @(posedge clk) begin
		if (state_q == pea_pkg::ST_READ) begin
			terms_s2 <= terms;
			entry_s2 <= rd_entry;
		end
		if (state_q == pea_pkg::ST_SUM) begin
			// Wrap the sum modulo 2^32.
			sum_s3    <= terms_s2.wake_term + terms_s2.switch_term
				+ pea_pkg::DATA_W'(terms_s2.small_sum);
			credit_s3 <= terms_s2.credit;
			entry_s3  <= entry_s2;
		end
	end

	// Floor at zero when the sleep credit covers the whole sum.
	assign credit_ext = pea_pkg::DATA_W'(credit_s3);
	assign score      = (credit_ext >= sum_s3) ? '0 : sum_s3 - credit_ext;

	always_comb begin
		final_entry            = entry_s3;
		final_entry.last_score = score;
	end

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pea_pkg::ST_SWEEP;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pea_pkg::ST_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = slot_s1;
		mem_wdata = upd_entry;
		case (state_q)
			pea_pkg::ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = '0;
				if (sweep_q == LAST_SLOT) begin
					state_d = pea_pkg::ST_IDLE;
				end
			end
			pea_pkg::ST_IDLE: begin
				// Drop beats that name no entry or no command.
				if (accept && item_ok) begin
					state_d = pea_pkg::ST_READ;
				end
			end
			pea_pkg::ST_READ: begin
				if (cmd_s1 == pea_pkg::CMD_SCORE) begin
					state_d = pea_pkg::ST_SUM;
				end else begin
					mem_we  = 1'b1;
					state_d = pea_pkg::ST_IDLE;
				end
			end
			pea_pkg::ST_SUM: begin
				state_d = pea_pkg::ST_FINAL;
			end
			pea_pkg::ST_FINAL: begin
				mem_we    = 1'b1;
				mem_wdata = final_entry;
				state_d   = pea_pkg::ST_IDLE;
			end
			default: begin
				state_d = pea_pkg::ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------- result
	logic                         strobe_q;
	logic [pea_pkg::IDX_W-1:0]    scored_process_q;
	logic [pea_pkg::DATA_W-1:0]   proc_score_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == pea_pkg::ST_FINAL);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pea_pkg::ST_FINAL) begin
			scored_process_q <= idx_s1;
			proc_score_q     <= score;
		end
	end

	assign strobe         = strobe_q;
	assign scored_process = scored_process_q;
	assign proc_score     = proc_score_q;

	// ---------------------------------------------------------------- checks
	`PEA_ASSERT_NOW(a_strobe_after_final, clk, arst_n, strobe, $past(state_q == pea_pkg::ST_FINAL), "result strobe without a finished score")
	`PEA_ASSERT_NEXT(a_valid_beat_busy, clk, arst_n, accept && item_ok, busy, "valid beat did not start a table access")
	`PEA_ASSERT_NOW(a_idle_no_write, clk, arst_n, state_q == pea_pkg::ST_IDLE, !mem_we, "table written while idle")

endmodule

`default_nettype wire
